// ----- rtl/gbk_pkg.sv -----
// ----------------------------------------------------------------------------
// gbk_pkg
// Shared widths, operation codes, state type and the structs that travel
// between the group table top level, its rows and its cells.
// ----------------------------------------------------------------------------
package gbk_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int ROW_CELLS   = 16;
    localparam int IDX_W       = 8;
    localparam int KEY_W       = 16;
    localparam int CNT_W       = 32;
    localparam int USED_W      = 9;
    localparam int OP_W        = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_TALLY  = 2'd0,
        OP_ASSIGN = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_TOTAL,
        ST_DONE
    } t_state;

    // lookup request seen by every cell
    typedef struct packed {
        logic              by_index;
        logic [KEY_W-1:0]  key;
        logic [IDX_W-1:0]  index;
        logic [USED_W-1:0] used;
    } t_query;

    // write port of the table, decoded by each cell
    typedef struct packed {
        logic              en;
        logic              key_en;
        logic [IDX_W-1:0]  index;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  count;
    } t_wr;

    // match result passed along the chain; stored keys are distinct,
    // so at most one cell contributes and an OR merges them
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  index;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  count;
    } t_part;

endpackage

// ----- rtl/group_by_key_counter.sv -----
// ----------------------------------------------------------------------------
// group_by_key_counter
// Table of distinct keys with hit counts, groups numbered in first-seen order.
// ----------------------------------------------------------------------------
// The table holds min(MAX_GROUPS, 256) entries as a chain of cells, 16 to a
// row. A lookup (tally, assign or read) reaches the result register through
// a chain of registers: the query is latched at the transfer, every cell
// compares at once and the match runs along each row into a row register, the
// rows are merged into one register, and the update of the matched or newly
// opened entry is written together with the result, which is loaded once
// the output register is free; o_ready rises again in the cycle after the
// result is loaded. A skipped tally and a clear bypass the rows and go from
// the latched query straight to the result register. One item is in work at
// a time; the result register lets the block finish an item while the previous
// result still waits, and a new item is taken once the result is loaded.
// ----------------------------------------------------------------------------
module group_by_key_counter
    import gbk_pkg::*;
#(
    parameter int MAX_GROUPS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [KEY_W-1:0]  i_material_key,
    input  logic              i_is_rendering,
    input  logic [IDX_W-1:0]  i_entry_index,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [IDX_W-1:0]  o_group_index,
    output logic              o_found,
    output logic              o_new_group,
    output logic              o_skipped,
    output logic              o_table_full,
    output logic [CNT_W-1:0]  o_hit_count,
    output logic [KEY_W-1:0]  o_entry_key,
    output logic [USED_W-1:0] o_group_total
);

    localparam int CAP   = (MAX_GROUPS < STORE_DEPTH) ? MAX_GROUPS : STORE_DEPTH;
    localparam int NROWS = (CAP + ROW_CELLS - 1) / ROW_CELLS;

    t_state            r_state, n_state;
    t_op               r_op;
    logic              r_rend;
    t_query            w_query;
    logic [KEY_W-1:0]  r_key;
    logic [IDX_W-1:0]  r_index;
    logic [USED_W-1:0] r_used, n_used;
    t_part             w_row_part [NROWS];
    t_part             r_total, n_total;
    t_wr               w_wr;
    logic              w_accept;
    logic              w_load;
    logic [CNT_W-1:0]  w_count_inc;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_group_index, n_group_index;
    logic              r_found, n_found;
    logic              r_new_group, n_new_group;
    logic              r_skipped, n_skipped;
    logic              r_table_full, n_table_full;
    logic [CNT_W-1:0]  r_hit_count, n_hit_count;
    logic [KEY_W-1:0]  r_entry_key, n_entry_key;
    logic [USED_W-1:0] r_group_total;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_load   = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    assign w_query.by_index = (r_op == OP_READ);
    assign w_query.key      = r_key;
    assign w_query.index    = r_index;
    assign w_query.used     = r_used;

    for (genvar r = 0; r < NROWS; r++) begin : g_row
        localparam int LEN = (r == NROWS - 1) ? (CAP - r * ROW_CELLS) : ROW_CELLS;
        gbk_row #(
            .ROW_BASE (r * ROW_CELLS),
            .ROW_LEN  (LEN)
        ) u_row (
            .i_clk   (i_clk),
            .i_query (w_query),
            .i_wr    (w_wr),
            .o_part  (w_row_part[r])
        );
    end

    always_comb begin
        n_total = '0;
        for (int r = 0; r < NROWS; r++) begin
            n_total = t_part'(n_total | w_row_part[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        if (w_accept) begin
            r_op    <= t_op'(i_operation);
            r_key   <= i_material_key;
            r_rend  <= i_is_rendering;
            r_index <= i_entry_index;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if ((t_op'(i_operation) == OP_CLEAR) ||
                        ((t_op'(i_operation) == OP_TALLY) && !i_is_rendering)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_ROW;
                    end
                end
            end
            ST_ROW:   n_state = ST_TOTAL;
            ST_TOTAL: n_state = ST_DONE;
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    assign w_count_inc = (r_total.count == COUNT_MAX) ? COUNT_MAX
                                                      : r_total.count + CNT_W'(1);

    // result, table write and fill count
    always_comb begin
        n_group_index = '0;
        n_found       = 1'b0;
        n_new_group   = 1'b0;
        n_skipped     = 1'b0;
        n_table_full  = 1'b0;
        n_hit_count   = '0;
        n_entry_key   = '0;
        n_used        = r_used;
        w_wr          = '0;
        case (r_op)
            OP_TALLY: begin
                if (!r_rend) begin
                    n_skipped = 1'b1;
                end else if (r_total.hit) begin
                    n_group_index = r_total.index;
                    n_found       = 1'b1;
                    n_hit_count   = w_count_inc;
                    n_entry_key   = r_total.key;
                    w_wr.en       = w_load;
                    w_wr.index    = r_total.index;
                    w_wr.count    = w_count_inc;
                end else if (r_used >= USED_W'(CAP)) begin
                    n_table_full = 1'b1;
                end else begin
                    n_group_index = r_used[IDX_W-1:0];
                    n_new_group   = 1'b1;
                    n_hit_count   = CNT_W'(1);
                    n_entry_key   = r_key;
                    n_used        = r_used + USED_W'(1);
                    w_wr.en       = w_load;
                    w_wr.key_en   = 1'b1;
                    w_wr.index    = r_used[IDX_W-1:0];
                    w_wr.key      = r_key;
                    w_wr.count    = CNT_W'(1);
                end
            end
            OP_ASSIGN, OP_READ: begin
                if (r_total.hit) begin
                    n_group_index = r_total.index;
                    n_found       = 1'b1;
                    n_hit_count   = r_total.count;
                    n_entry_key   = r_total.key;
                end
            end
            OP_CLEAR: begin
                n_used = '0;
            end
            default: begin
                n_used = r_used;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_used      <= n_used;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result until the transfer out
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_group_index <= n_group_index;
            r_found       <= n_found;
            r_new_group   <= n_new_group;
            r_skipped     <= n_skipped;
            r_table_full  <= n_table_full;
            r_hit_count   <= n_hit_count;
            r_entry_key   <= n_entry_key;
            r_group_total <= n_used;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_group_index = r_group_index;
    assign o_found       = r_found;
    assign o_new_group   = r_new_group;
    assign o_skipped     = r_skipped;
    assign o_table_full  = r_table_full;
    assign o_hit_count   = r_hit_count;
    assign o_entry_key   = r_entry_key;
    assign o_group_total = r_group_total;

endmodule

// ----- rtl/gbk_cell.sv -----
// ----------------------------------------------------------------------------
// gbk_cell
// One table entry: holds a key and its count, compares against the query
// and merges its match into the result handed on to the next cell.
// ----------------------------------------------------------------------------
module gbk_cell
    import gbk_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic   i_clk,
    input  t_query i_query,
    input  t_wr    i_wr,
    input  t_part  i_part,
    output t_part  o_part
);

    localparam logic [IDX_W-1:0] ME = IDX_W'(CELL_INDEX);

    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_count;
    logic             w_hit;
    t_part            w_mine;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.index == ME)) begin
            r_count <= i_wr.count;
            if (i_wr.key_en) begin
                r_key <= i_wr.key;
            end
        end
    end

    // only entries below the fill count take part
    always_comb begin
        w_hit = ({1'b0, ME} < i_query.used) &&
                (i_query.by_index ? (i_query.index == ME) : (i_query.key == r_key));
        w_mine = '0;
        if (w_hit) begin
            w_mine.hit   = 1'b1;
            w_mine.index = ME;
            w_mine.key   = r_key;
            w_mine.count = r_count;
        end
        o_part = t_part'(i_part | w_mine);
    end

endmodule

// ----- rtl/gbk_row.sv -----
// ----------------------------------------------------------------------------
// gbk_row
// A run of cells chained left to right; the merged match at the end of the
// run is registered for the top level.
// ----------------------------------------------------------------------------
module gbk_row
    import gbk_pkg::*;
#(
    parameter int ROW_BASE = 0,
    parameter int ROW_LEN  = 16
) (
    input  logic   i_clk,
    input  t_query i_query,
    input  t_wr    i_wr,
    output t_part  o_part
);

    t_part w_chain [ROW_LEN+1];
    t_part r_part;

    assign w_chain[0] = '0;

    for (genvar c = 0; c < ROW_LEN; c++) begin : g_cell
        gbk_cell #(
            .CELL_INDEX (ROW_BASE + c)
        ) u_cell (
            .i_clk   (i_clk),
            .i_query (i_query),
            .i_wr    (i_wr),
            .i_part  (w_chain[c]),
            .o_part  (w_chain[c+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_part <= w_chain[ROW_LEN];
    end

    assign o_part = r_part;

endmodule
